// ===== rtl/chg_pkg.sv =====
// Shared types, register codes and reset constants for the cone height generator.
// Every module of the block imports this package; it depends on nothing else.
package chg_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int PIX_W    = 10;
  localparam int CENTER_W = 15;
  localparam int RADIUS_W = 15;
  localparam int PEAK_W   = 16;
  localparam int SQ_W     = 32;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;
  localparam logic [1:0] REG_PEAK     = 2'd3;

  localparam logic signed [CENTER_W-1:0] RST_CENTER = '0;
  localparam logic [RADIUS_W-1:0]        RST_RADIUS = 15'd16;
  localparam logic signed [PEAK_W-1:0]   RST_PEAK   = 16'sd256;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic signed [PEAK_W-1:0] elevation;
    logic                     inside_res;
  } result_t;

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic vld;
    logic onmap;
  } chg_ctl_t;

endpackage

// ===== rtl/chg_offset.sv =====
// Front of the pipeline: offsets from the center, their squares and the sum.
// Three register stages; depends on chg_pkg.
module chg_offset #(
  parameter int MAX_WIDTH  = chg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = chg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     vld_in,
  input  chg_pkg::pixel_t                          pix,
  input  logic signed [chg_pkg::CENTER_W-1:0]      center_x,
  input  logic signed [chg_pkg::CENTER_W-1:0]      center_y,
  output chg_pkg::chg_ctl_t                        ctl_out,
  output logic [chg_pkg::SQ_W-1:0]                 sq
);
  import chg_pkg::*;

  localparam logic [PIX_W:0] W_LIM = (PIX_W+1)'(MAX_WIDTH);
  localparam logic [PIX_W:0] H_LIM = (PIX_W+1)'(MAX_HEIGHT);

  chg_ctl_t           ctl1, ctl2, ctl3;
  logic signed [16:0] dx, dy;
  logic [29:0]        sqx, sqy;
  logic [SQ_W-1:0]    sum;

  logic signed [16:0] dx_next, dy_next;
  logic signed [33:0] sqx_full, sqy_full;

  // Pixel position scaled to sixteenths, minus the sign-extended center.
  assign dx_next = $signed({3'b000, pix.pixel_x, 4'b0000}) - {{2{center_x[CENTER_W-1]}}, center_x};
  assign dy_next = $signed({3'b000, pix.pixel_y, 4'b0000}) - {{2{center_y[CENTER_W-1]}}, center_y};
  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.vld <= 1'b0;
      ctl2.vld <= 1'b0;
      ctl3.vld <= 1'b0;
    end else if (en) begin
      ctl1.vld <= vld_in;
      ctl2.vld <= ctl1.vld;
      ctl3.vld <= ctl2.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1.onmap <= ({1'b0, pix.pixel_x} < W_LIM) && ({1'b0, pix.pixel_y} < H_LIM);
      dx         <= dx_next;
      dy         <= dy_next;
      ctl2.onmap <= ctl1.onmap;
      sqx        <= sqx_full[29:0];
      sqy        <= sqy_full[29:0];
      ctl3.onmap <= ctl2.onmap;
      sum        <= SQ_W'({1'b0, sqx} + {1'b0, sqy});
    end
  end

  assign ctl_out = ctl3;
  assign sq      = sum;

endmodule

// ===== rtl/chg_sqrt.sv =====
// Pipelined integer square root, rounded down: one result bit per register stage.
// Sixteen stages for a 32-bit radicand; depends on chg_pkg.
module chg_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  chg_pkg::chg_ctl_t             ctl_in,
  input  logic [chg_pkg::SQ_W-1:0]      sq,
  output chg_pkg::chg_ctl_t             ctl_out,
  output logic [chg_pkg::ROOT_W-1:0]    distance
);
  import chg_pkg::*;

  logic [ROOT_W:0]   rem  [1:ROOT_W];
  logic [ROOT_W-1:0] root [1:ROOT_W];
  logic [SQ_W-1:0]   rad  [1:ROOT_W];
  chg_ctl_t          ctl  [1:ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_step
    logic [ROOT_W:0]   src_rem;
    logic [ROOT_W-1:0] src_root;
    logic [SQ_W-1:0]   src_rad;
    chg_ctl_t          src_ctl;
    logic [ROOT_W+2:0] acc;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              take;

    if (g == 0) begin : g_first
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_rad  = sq;
      assign src_ctl  = ctl_in;
    end else begin : g_next
      assign src_rem  = rem[g];
      assign src_root = root[g];
      assign src_rad  = rad[g];
      assign src_ctl  = ctl[g];
    end

    // Bring down the next two radicand bits and try the digit one.
    assign acc   = {src_rem, src_rad[SQ_W-1-2*g -: 2]};
    assign trial = {1'b0, src_root, 2'b01};
    assign take  = acc >= trial;
    assign diff  = acc - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[g+1].vld <= 1'b0;
      end else if (en) begin
        ctl[g+1].vld <= src_ctl.vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl[g+1].onmap <= src_ctl.onmap;
        rem[g+1]       <= take ? diff[ROOT_W:0] : acc[ROOT_W:0];
        root[g+1]      <= {src_root[ROOT_W-2:0], take};
        rad[g+1]       <= src_rad;
      end
    end
  end

  assign ctl_out  = ctl[ROOT_W];
  assign distance = root[ROOT_W];

endmodule

// ===== rtl/chg_div.sv =====
// Back of the pipeline: inside test, peak times (radius - distance), a restoring
// divide by the radius one quotient bit per stage, and the signed output register.
// Depends on chg_pkg.
module chg_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  chg_pkg::chg_ctl_t                   ctl_in,
  input  logic [chg_pkg::ROOT_W-1:0]          distance,
  input  logic [chg_pkg::RADIUS_W-1:0]        radius,
  input  logic signed [chg_pkg::PEAK_W-1:0]   peak,
  output logic                                res_valid,
  output chg_pkg::result_t                    res
);
  import chg_pkg::*;

  localparam int Q_W = 16;

  // Stage A: inside test and operands of the product.
  logic                vld_a, inside_a, neg_a;
  logic [RADIUS_W-1:0] span_a;
  logic [PEAK_W-1:0]   mag_a;
  // Stage B: product.
  logic                vld_b, inside_b, neg_b;
  logic [30:0]         prod_b;

  logic                    in_range;
  logic [PEAK_W-1:0]       peak_mag;

  logic [RADIUS_W-1:0] rem   [1:Q_W];
  logic [Q_W-1:0]      quot  [1:Q_W];
  logic [Q_W-1:0]      low   [1:Q_W];
  logic                vld_d [1:Q_W];
  logic                ins_d [1:Q_W];
  logic                neg_d [1:Q_W];

  assign in_range = ctl_in.onmap && (distance <= {1'b0, radius});
  assign peak_mag = peak[PEAK_W-1] ? PEAK_W'(-peak) : peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
    end else if (en) begin
      vld_a <= ctl_in.vld;
      vld_b <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside_a <= in_range;
      span_a   <= in_range ? radius - distance[RADIUS_W-1:0] : '0;
      mag_a    <= peak_mag;
      neg_a    <= peak[PEAK_W-1];
      inside_b <= inside_a;
      neg_b    <= neg_a;
      prod_b   <= {15'b0, mag_a} * {16'b0, span_a};
    end
  end

  // The quotient never exceeds the peak magnitude, so the upper product bits
  // already lie below the radius and only the low sixteen bits are shifted in.
  for (genvar g = 0; g < Q_W; g++) begin : g_step
    logic [RADIUS_W-1:0] src_rem;
    logic [Q_W-1:0]      src_quot;
    logic [Q_W-1:0]      src_low;
    logic                src_vld, src_ins, src_neg;
    logic [RADIUS_W:0]   acc;
    logic [RADIUS_W:0]   diff;
    logic                take;

    if (g == 0) begin : g_first
      assign src_rem  = prod_b[30:16];
      assign src_quot = '0;
      assign src_low  = prod_b[15:0];
      assign src_vld  = vld_b;
      assign src_ins  = inside_b;
      assign src_neg  = neg_b;
    end else begin : g_next
      assign src_rem  = rem[g];
      assign src_quot = quot[g];
      assign src_low  = low[g];
      assign src_vld  = vld_d[g];
      assign src_ins  = ins_d[g];
      assign src_neg  = neg_d[g];
    end

    assign acc  = {src_rem, src_low[Q_W-1-g]};
    assign take = acc >= {1'b0, radius};
    assign diff = acc - {1'b0, radius};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_d[g+1] <= 1'b0;
      end else if (en) begin
        vld_d[g+1] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1]   <= take ? diff[RADIUS_W-1:0] : acc[RADIUS_W-1:0];
        quot[g+1]  <= {src_quot[Q_W-2:0], take};
        low[g+1]   <= src_low;
        ins_d[g+1] <= src_ins;
        neg_d[g+1] <= src_neg;
      end
    end
  end

  // Output register: quotient magnitude takes the sign of the peak.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= vld_d[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.elevation  <= neg_d[Q_W] ? $signed(PEAK_W'(-quot[Q_W])) : $signed(quot[Q_W]);
      res.inside_res <= ins_d[Q_W];
    end
  end

endmodule

// ===== rtl/cone_height_generator.sv =====
// Cone height generator: each input transfer passes through the offset, square root and divide stages to its result.
// Throughput is one pixel per clock; the input stalls only while a finished result
// is held by a stalled output, which freezes the whole 38-stage pipeline.
// Most of those stages lie in the 16-stage square root and the 16-stage radius divide.
// Reset (synchronous, active high) empties the pipeline and loads the register
// reset values: center 0,0, radius 16, peak 256.
module cone_height_generator #(
  parameter int MAX_WIDTH  = chg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = chg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  chg_pkg::pixel_t               in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output chg_pkg::result_t              out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [chg_pkg::ADDR_W-1:0]    paddr,
  input  logic [chg_pkg::DATA_W-1:0]    pwdata,
  output logic [chg_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import chg_pkg::*;

  logic signed [CENTER_W-1:0] center_x;
  logic signed [CENTER_W-1:0] center_y;
  logic [RADIUS_W-1:0]        cone_radius;
  logic signed [PEAK_W-1:0]   peak_height;

  logic                en;
  logic                wr;
  logic [RADIUS_W-1:0] radius_eff;
  chg_ctl_t            ctl_sq, ctl_rt;
  logic [SQ_W-1:0]     sq;
  logic [ROOT_W-1:0]   distance;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= RST_CENTER;
      center_y    <= RST_CENTER;
      cone_radius <= RST_RADIUS;
      peak_height <= RST_PEAK;
    end else if (wr) begin
      case (paddr[3:2])
        REG_CENTER_X: center_x    <= pwdata[CENTER_W-1:0];
        REG_CENTER_Y: center_y    <= pwdata[CENTER_W-1:0];
        REG_RADIUS:   cone_radius <= pwdata[RADIUS_W-1:0];
        REG_PEAK:     peak_height <= pwdata[PEAK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CENTER_X: prdata = DATA_W'(signed'(center_x));
      REG_CENTER_Y: prdata = DATA_W'(signed'(center_y));
      REG_RADIUS:   prdata = DATA_W'(cone_radius);
      REG_PEAK:     prdata = DATA_W'(signed'(peak_height));
      default:      prdata = '0;
    endcase
  end

  // A zero radius divides as one.
  assign radius_eff = (cone_radius == '0) ? RADIUS_W'(1) : cone_radius;

  // All stages advance together unless the output holds a stalled transfer.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  chg_offset #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_offset (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (in_valid),
    .pix      (in_data),
    .center_x (center_x),
    .center_y (center_y),
    .ctl_out  (ctl_sq),
    .sq       (sq)
  );

  chg_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (ctl_sq),
    .sq       (sq),
    .ctl_out  (ctl_rt),
    .distance (distance)
  );

  chg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctl_in    (ctl_rt),
    .distance  (distance),
    .radius    (radius_eff),
    .peak      (peak_height),
    .res_valid (out_valid),
    .res       (out_data)
  );

  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_outside_is_flat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.inside_res) |-> (out_data.elevation == '0))
    else $error("nonzero elevation outside the cone");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule
